// ----- hw/rtl/framed_command_handler_crc16_defines.svh -----
// ----------------------------------------------------------------------------
// Framed command handler: assertion macros
// Shared property shorthands for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_HANDLER_CRC16_DEFINES_SVH
`define FRAMED_COMMAND_HANDLER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed command handler: check failed");

// Next-cycle implication, disabled during reset
`define FCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framed command handler: check failed");

`endif

// ----- hw/rtl/fch_pkg.sv -----
// ----------------------------------------------------------------------------
// fch_pkg
// Constants and types shared by the framed command handler modules.
// ----------------------------------------------------------------------------
package fch_pkg;

    localparam int FRAME_LEN = 7;
    localparam int BODY_LEN  = 5;
    localparam int CRC_CNT_W = $clog2(8 + 1);

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] ACK_BYTE    = 8'h05;
    localparam logic [7:0] NACK_BYTE   = 8'h15;
    localparam logic [7:0] OP_READ     = 8'h31;
    localparam logic [7:0] OP_WRITE    = 8'h32;
    localparam logic [7:0] SUB_VERSION = 8'h30;
    localparam logic [7:0] SUB_TIME    = 8'h31;
    localparam logic [7:0] SUB_DATE    = 8'h32;
    localparam logic [7:0] SUB_ALARM   = 8'h33;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;

    // Reset values of the stored settings
    localparam logic [7:0] RST_VERSION   = 8'd1;
    localparam logic [7:0] RST_REVISION  = 8'd2;
    localparam logic [7:0] RST_HOUR      = 8'd0;
    localparam logic [7:0] RST_MINUTE    = 8'd0;
    localparam logic [7:0] RST_SECOND    = 8'd0;
    localparam logic [7:0] RST_DAY       = 8'd4;
    localparam logic [7:0] RST_MONTH     = 8'd6;
    localparam logic [15:0] RST_YEAR     = 16'd2018;
    localparam logic [7:0] RST_ALARM_HR  = 8'd5;
    localparam logic [7:0] RST_ALARM_MIN = 8'd10;

    // Five-byte reply or frame body
    typedef logic [BODY_LEN-1:0][7:0] body_t;

    // Command to the bit-serial CRC unit
    typedef struct packed {
        logic load;  // take a byte and start shifting it in
        logic init;  // restart the CRC from its initial value
    } crc_cmd_t;

endpackage

// ----- hw/rtl/fch_crc.sv -----
// ----------------------------------------------------------------------------
// fch_crc
// Bit-serial CRC-16/X-25 unit: one byte is loaded, then shifted in LSB first.
// ----------------------------------------------------------------------------
module fch_crc
    import fch_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  crc_cmd_t       cmd,
    input  logic [7:0]     data,
    output logic           busy,
    output logic [15:0]    result
);

    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           sh_reg, sh_next;
    logic [CRC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 fb;

    assign busy   = (cnt_reg != '0);
    assign result = ~crc_reg;
    assign fb     = crc_reg[0] ^ sh_reg[0];

    // Load a byte or advance one bit
    always_comb
    begin
        crc_next = crc_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            sh_next  = data;
            cnt_next = CRC_CNT_W'(8);
            if (cmd.init)
            begin
                crc_next = CRC_INIT;
            end
        end
        else if (busy)
        begin
            crc_next = (crc_reg >> 1) ^ (fb ? CRC_POLY : 16'h0000);
            sh_next  = sh_reg >> 1;
            cnt_next = cnt_reg - CRC_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

// ----- hw/rtl/fch_regs.sv -----
// ----------------------------------------------------------------------------
// fch_regs
// Stored settings and reply body; decodes a checked frame into a read reply
// or an echo with a settings update.
// ----------------------------------------------------------------------------
module fch_regs
    import fch_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  apply,
    input  body_t frame,
    output body_t reply
);

    body_t      reply_reg, reply_next;
    logic [7:0] version_reg, version_next;
    logic [7:0] revision_reg, revision_next;
    logic [7:0] hour_reg, hour_next;
    logic [7:0] minute_reg, minute_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] day_reg, day_next;
    logic [7:0] month_reg, month_next;
    // only the low byte of the year is ever sent back
    logic [7:0] year_lo_reg, year_lo_next;
    logic [7:0] alarm_hr_reg, alarm_hr_next;
    logic [7:0] alarm_min_reg, alarm_min_next;

    logic [7:0] v2, v3, v4;

    assign reply = reply_reg;
    assign v2    = frame[2] - ASCII_ZERO;
    assign v3    = frame[3] - ASCII_ZERO;
    assign v4    = frame[4] - ASCII_ZERO;

    // Decode op and subcommand
    always_comb
    begin
        reply_next     = reply_reg;
        version_next   = version_reg;
        revision_next  = revision_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_lo_next   = year_lo_reg;
        alarm_hr_next  = alarm_hr_reg;
        alarm_min_next = alarm_min_reg;
        if (apply && frame[0] == OP_READ)
        begin
            reply_next[0] = frame[0];
            reply_next[1] = frame[1];
            case (frame[1])
                SUB_VERSION:
                begin
                    reply_next[2] = version_reg;
                    reply_next[3] = revision_reg;
                    reply_next[4] = 8'h00;
                end
                SUB_TIME:
                begin
                    reply_next[2] = hour_reg;
                    reply_next[3] = minute_reg;
                    reply_next[4] = second_reg;
                end
                SUB_DATE:
                begin
                    reply_next[2] = day_reg;
                    reply_next[3] = month_reg;
                    reply_next[4] = year_lo_reg;
                end
                SUB_ALARM:
                begin
                    reply_next[2] = alarm_hr_reg;
                    reply_next[3] = alarm_min_reg;
                    reply_next[4] = FILL_BYTE;
                end
                default:
                begin
                    // unknown subcommand keeps the old value bytes
                end
            endcase
        end
        else if (apply && frame[0] == OP_WRITE)
        begin
            reply_next = frame;
            case (frame[1])
                SUB_VERSION:
                begin
                    version_next  = v2;
                    revision_next = v3;
                end
                SUB_TIME:
                begin
                    hour_next   = v2;
                    minute_next = v3;
                    second_next = v4;
                end
                SUB_DATE:
                begin
                    day_next     = v2;
                    month_next   = v3;
                    year_lo_next = v4;
                end
                SUB_ALARM:
                begin
                    alarm_hr_next  = v2;
                    alarm_min_next = v3;
                end
                default:
                begin
                    // echo only
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_reg     <= '0;
            version_reg   <= RST_VERSION;
            revision_reg  <= RST_REVISION;
            hour_reg      <= RST_HOUR;
            minute_reg    <= RST_MINUTE;
            second_reg    <= RST_SECOND;
            day_reg       <= RST_DAY;
            month_reg     <= RST_MONTH;
            year_lo_reg   <= RST_YEAR[7:0];
            alarm_hr_reg  <= RST_ALARM_HR;
            alarm_min_reg <= RST_ALARM_MIN;
        end
        else
        begin
            reply_reg     <= reply_next;
            version_reg   <= version_next;
            revision_reg  <= revision_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_lo_reg   <= year_lo_next;
            alarm_hr_reg  <= alarm_hr_next;
            alarm_min_reg <= alarm_min_next;
        end
    end

endmodule

// ----- hw/rtl/framed_command_handler_crc16.sv -----
// ----------------------------------------------------------------------------
// framed_command_handler_crc16
// Gathers 7-byte command frames, checks their CRC-16/X-25 and sends
// NACK, or ACK followed by a 7-byte response with its own CRC.
// ----------------------------------------------------------------------------
// Each of the first five frame bytes is taken in one transfer, then rx_stall
// stays high while the single bit-serial CRC unit shifts it in and until the
// block returns to receiving. The two CRC bytes are taken without a stall.
// The check is made once the output register is free. For a good frame the
// same CRC unit then runs over the five reply bytes, after which the seven
// reply bytes leave at one per cycle while the output is not stalled. The
// next frame is taken only once the reply is loaded for sending; the cost of
// a good frame is set by the CRC unit working one bit per cycle, and a
// stalled output adds its stall cycles. last flags the final byte of each
// reply; a NACK reply is one byte long.
module framed_command_handler_crc16
    import fch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       last
);

    typedef enum logic [4:0] {
        S_RX      = 5'b00001,
        S_CRC_IN  = 5'b00010,
        S_CHECK   = 5'b00100,
        S_CRC_OUT = 5'b01000,
        S_SEND    = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] frame_reg [FRAME_LEN];

    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       last_reg, last_next;

    logic       rx_xfer;
    logic       out_free;
    logic       out_load;
    logic [7:0] out_byte;
    logic       out_last;
    logic       crc_ok;
    logic       apply;

    crc_cmd_t   crc_cmd;
    logic [7:0] crc_data;
    logic       crc_busy;
    logic [15:0] crc_result;

    body_t      frame_body;
    body_t      reply;
    logic [7:0] reply_sel;

    assign rx_stall = (state_reg != S_RX);
    assign rx_xfer  = rx_valid && !rx_stall;
    assign out_free = !tx_valid_reg || !tx_stall;
    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign last     = last_reg;

    assign crc_ok = (crc_result[7:0] == frame_reg[5]) && (crc_result[15:8] == frame_reg[6]);

    always_comb
    begin
        for (int i = 0; i < BODY_LEN; i++)
        begin
            frame_body[i] = frame_reg[i];
        end
    end

    // Reply byte at the current index (only indexes below the body length)
    always_comb
    begin
        reply_sel = 8'h00;
        for (int i = 0; i < BODY_LEN; i++)
        begin
            if (idx_reg == 3'(i))
            begin
                reply_sel = reply[i];
            end
        end
    end

    // Frame byte capture
    always_ff @(posedge clk)
    begin
        if (rx_xfer)
        begin
            frame_reg[cnt_reg] <= rx_byte;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        crc_cmd.load = 1'b0;
        crc_cmd.init = 1'b0;
        crc_data     = rx_byte;
        out_load     = 1'b0;
        out_byte     = ACK_BYTE;
        out_last     = 1'b0;
        apply        = 1'b0;
        case (state_reg)
            S_RX:
            begin
                if (rx_xfer)
                begin
                    if (cnt_reg < 3'(BODY_LEN))
                    begin
                        crc_cmd.load = 1'b1;
                        crc_cmd.init = (cnt_reg == 3'd0);
                        state_next   = S_CRC_IN;
                    end
                    if (cnt_reg == 3'(FRAME_LEN - 1))
                    begin
                        cnt_next   = 3'd0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_CRC_IN:
            begin
                if (!crc_busy)
                begin
                    state_next = S_RX;
                end
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (crc_ok)
                    begin
                        apply      = 1'b1;
                        idx_next   = 3'd0;
                        state_next = S_CRC_OUT;
                    end
                    else
                    begin
                        out_byte   = NACK_BYTE;
                        out_last   = 1'b1;
                        state_next = S_RX;
                    end
                end
            end
            S_CRC_OUT:
            begin
                crc_data = reply_sel;
                if (!crc_busy)
                begin
                    if (idx_reg < 3'(BODY_LEN))
                    begin
                        crc_cmd.load = 1'b1;
                        crc_cmd.init = (idx_reg == 3'd0);
                        idx_next     = idx_reg + 3'd1;
                    end
                    else
                    begin
                        idx_next   = 3'd0;
                        state_next = S_SEND;
                    end
                end
            end
            S_SEND:
            begin
                if (idx_reg == 3'(BODY_LEN))
                begin
                    out_byte = crc_result[7:0];
                end
                else if (idx_reg == 3'(BODY_LEN + 1))
                begin
                    out_byte = crc_result[15:8];
                    out_last = 1'b1;
                end
                else
                begin
                    out_byte = reply_sel;
                end
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (out_last)
                    begin
                        idx_next   = 3'd0;
                        state_next = S_RX;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    // Output register: load a new transfer or drop a taken one
    always_comb
    begin
        tx_valid_next = tx_valid_reg;
        tx_byte_next  = tx_byte_reg;
        last_next     = last_reg;
        if (out_load)
        begin
            tx_valid_next = 1'b1;
            tx_byte_next  = out_byte;
            last_next     = out_last;
        end
        else if (!tx_stall)
        begin
            tx_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RX;
            cnt_reg      <= 3'd0;
            idx_reg      <= 3'd0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg <= tx_byte_next;
        last_reg    <= last_next;
    end

    fch_crc u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (crc_cmd),
        .data   (crc_data),
        .busy   (crc_busy),
        .result (crc_result)
    );

    fch_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (apply),
        .frame (frame_body),
        .reply (reply)
    );

endmodule

// ----- hw/rtl/fch_checker.sv -----
// ----------------------------------------------------------------------------
// fch_checker
// Port-level checks of the reply framing, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_command_handler_crc16_defines.svh"

module fch_checker
    import fch_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_stall,
    input logic       tx_valid,
    input logic       tx_stall,
    input logic [7:0] tx_byte,
    input logic       last
);

    logic [2:0] pos_reg, pos_next;
    logic       tx_xfer;
    logic       rx_xfer;

    assign tx_xfer = tx_valid && !tx_stall;
    assign rx_xfer = rx_valid && !rx_stall;

    // Track the position of the next transfer within its reply
    always_comb
    begin
        pos_next = pos_reg;
        if (tx_xfer)
        begin
            pos_next = last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // A stalled transfer holds
    `FCH_ASSERT_NXT(a_tx_hold, clk, rst_n, tx_valid && tx_stall, tx_valid && $stable(tx_byte) && $stable(last))
    // Every reply opens with ACK or NACK
    `FCH_ASSERT_IMP(a_head_code, clk, rst_n, tx_valid && pos_reg == 3'd0, tx_byte == ACK_BYTE || tx_byte == NACK_BYTE)
    // NACK stands alone, ACK is followed by the response
    `FCH_ASSERT_IMP(a_head_last, clk, rst_n, tx_valid && pos_reg == 3'd0, last == (tx_byte == NACK_BYTE))
    // An acknowledged reply is eight bytes long
    `FCH_ASSERT_IMP(a_reply_len, clk, rst_n, tx_valid && last && pos_reg != 3'd0, pos_reg == 3'd7)
    // Hold off input while a response is still being sent
    `FCH_ASSERT_IMP(a_rx_quiet, clk, rst_n, pos_reg != 3'd0 && pos_reg != 3'd7, !rx_xfer)

endmodule

bind framed_command_handler_crc16 fch_checker u_fch_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_byte  (tx_byte),
    .last     (last)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: framed command handler testbench
// Sends 7-byte command frames with good and bad CRCs, mixed with random noise, to
// framed_command_handler_crc16. A byte-level predictor rebuilds each reply.
// The monitor checks every transmitted byte and its last flag in order.
// Both channels idle at random in the first two of three phases. One long
// receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import fch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    logic       clk;
    logic       rst_n;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte  = 8'h00;
    logic       tx_valid;
    logic       tx_stall = 1'b0;
    logic [7:0] tx_byte;
    logic       last;

    // Handshake bookkeeping
    logic       rx_fire = 1'b0;
    int         rx_accepted = 0;
    int         send_gap_pct;
    int         recv_hold_pct;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         fail_count = 0;

    logic [7:0] rx_pending[$];
    tx_beat_t   tx_bytes_due[$];

    // Predicted state of the handler
    logic [7:0] frame_buf[FRAME_LEN];
    int         frame_fill = 0;
    body_t      reply_body = '0;
    logic [7:0] version_q   = RST_VERSION;
    logic [7:0] revision_q  = RST_REVISION;
    logic [7:0] hour_q      = RST_HOUR;
    logic [7:0] minute_q    = RST_MINUTE;
    logic [7:0] second_q    = RST_SECOND;
    logic [7:0] day_q       = RST_DAY;
    logic [7:0] month_q     = RST_MONTH;
    logic [15:0] year_q     = RST_YEAR;
    logic [7:0] alarm_hr_q  = RST_ALARM_HR;
    logic [7:0] alarm_min_q = RST_ALARM_MIN;

    framed_command_handler_crc16 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .tx_valid (tx_valid),
        .tx_stall (tx_stall),
        .tx_byte  (tx_byte),
        .last     (last)
    );

    // CRC-16/X-25 over a five-byte body, reflected, complemented at the end
    function automatic logic [15:0] x25_of(input body_t body);
        logic [15:0] acc;
        logic [7:0]  d;
        acc = CRC_INIT;
        for (int k = 0; k < BODY_LEN; k++) begin
            d = body[k];
            for (int i = 0; i < 8; i++) begin
                if (acc[0] ^ d[0])
                    acc = (acc >> 1) ^ CRC_POLY;
                else
                    acc = acc >> 1;
                d = d >> 1;
            end
        end
        return ~acc;
    endfunction

    // Mostly ASCII digits, sometimes any byte
    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 99) < 60)
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a frame with its CRC, optionally flip one bit, and queue it
    task automatic queue_frame(input logic [7:0] op, input logic [7:0] sub,
                               input logic [7:0] d2, input logic [7:0] d3,
                               input logic [7:0] d4, input bit corrupt);
        body_t       body;
        logic [15:0] crc;
        logic [55:0] frm;
        body[0] = op;
        body[1] = sub;
        body[2] = d2;
        body[3] = d3;
        body[4] = d4;
        crc = x25_of(body);
        frm = {crc[15:8], crc[7:0], body};
        if (corrupt)
            frm[$urandom_range(0, 55)] ^= 1'b1;
        for (int k = 0; k < FRAME_LEN; k++)
            rx_pending.push_back(frm[k*8 +: 8]);
    endtask

    // Gather one received byte; on the seventh, predict the whole reply
    task automatic take_rx_byte(input logic [7:0] b);
        body_t       body;
        logic [15:0] crc;
        frame_buf[frame_fill] = b;
        frame_fill++;
        if (frame_fill < FRAME_LEN)
            return;
        frame_fill = 0;
        for (int k = 0; k < BODY_LEN; k++)
            body[k] = frame_buf[k];
        crc = x25_of(body);
        if (frame_buf[5] != crc[7:0] || frame_buf[6] != crc[15:8]) begin
            tx_bytes_due.push_back('{data: NACK_BYTE, last: 1'b1});
            return;
        end
        tx_bytes_due.push_back('{data: ACK_BYTE, last: 1'b0});

        // Apply the command; unknown ops leave the reply body as it was
        if (body[0] == OP_READ) begin
            reply_body[0] = body[0];
            reply_body[1] = body[1];
            case (body[1])
                SUB_VERSION: begin
                    reply_body[2] = version_q;
                    reply_body[3] = revision_q;
                    reply_body[4] = 8'h00;
                end
                SUB_TIME: begin
                    reply_body[2] = hour_q;
                    reply_body[3] = minute_q;
                    reply_body[4] = second_q;
                end
                SUB_DATE: begin
                    reply_body[2] = day_q;
                    reply_body[3] = month_q;
                    reply_body[4] = year_q[7:0];
                end
                SUB_ALARM: begin
                    reply_body[2] = alarm_hr_q;
                    reply_body[3] = alarm_min_q;
                    reply_body[4] = FILL_BYTE;
                end
                default: ;
            endcase
        end else if (body[0] == OP_WRITE) begin
            reply_body = body;
            case (body[1])
                SUB_VERSION: begin
                    version_q  = body[2] - ASCII_ZERO;
                    revision_q = body[3] - ASCII_ZERO;
                end
                SUB_TIME: begin
                    hour_q   = body[2] - ASCII_ZERO;
                    minute_q = body[3] - ASCII_ZERO;
                    second_q = body[4] - ASCII_ZERO;
                end
                SUB_DATE: begin
                    day_q   = body[2] - ASCII_ZERO;
                    month_q = body[3] - ASCII_ZERO;
                    year_q  = {8'h00, body[4]} - {8'h00, ASCII_ZERO};
                end
                SUB_ALARM: begin
                    alarm_hr_q  = body[2] - ASCII_ZERO;
                    alarm_min_q = body[3] - ASCII_ZERO;
                end
                default: ;
            endcase
        end

        // Queue the body, then its CRC low byte first
        crc = x25_of(reply_body);
        for (int k = 0; k < BODY_LEN; k++)
            tx_bytes_due.push_back('{data: reply_body[k], last: 1'b0});
        tx_bytes_due.push_back('{data: crc[7:0], last: 1'b0});
        tx_bytes_due.push_back('{data: crc[15:8], last: 1'b1});
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle rates per phase: receiver sparse first, then sender, then neither
    always_comb begin
        if (rx_accepted < 140) begin
            send_gap_pct  = 18;
            recv_hold_pct = 76;
        end else if (rx_accepted < 280) begin
            send_gap_pct  = 76;
            recv_hold_pct = 18;
        end else begin
            send_gap_pct  = 0;
            recv_hold_pct = 0;
        end
    end

    // Driver: advance to the next byte once the current transfer is done
    always @(negedge clk) begin
        if (rst_n && (!rx_valid || rx_fire)) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                rx_valid <= 1'b1;
                rx_byte  <= rx_pending.pop_front();
            end else begin
                rx_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off late in the run
    always @(negedge clk) begin
        if (hold_left != 0) begin
            tx_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_accepted >= 320) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            tx_stall  <= 1'b1;
        end else begin
            tx_stall <= ($urandom_range(0, 99) < recv_hold_pct);
        end
    end

    // Monitor: check each tx transfer, then predict from each rx transfer
    always @(posedge clk) begin : monitor
        tx_beat_t due;
        rx_fire <= rst_n && rx_valid && !rx_stall;
        if (rst_n && tx_valid && !tx_stall) begin
            if (tx_bytes_due.size() == 0) begin
                $error("unexpected tx transfer: tx_byte %02h last %0b", tx_byte, last);
                fail_count++;
            end else begin
                due = tx_bytes_due.pop_front();
                if (tx_byte !== due.data) begin
                    $error("tx_byte: expected %02h, actual %02h", due.data, tx_byte);
                    fail_count++;
                end
                if (last !== due.last) begin
                    $error("last: expected %0b, actual %0b", due.last, last);
                    fail_count++;
                end
            end
        end
        if (rst_n && rx_valid && !rx_stall) begin
            rx_accepted++;
            take_rx_byte(rx_byte);
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [7:0] op;
        int         sel;

        // Unknown op before any reply: resend the all-zero body
        queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        // Write date with a year byte below '0' so the year wraps
        queue_frame(OP_WRITE, SUB_DATE, 8'hFF, 8'h2F, 8'h00, 1'b0);
        queue_frame(OP_READ, SUB_DATE, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // Bad CRC answers NACK alone
        queue_frame(FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 1'b1);

        // Random frames: mostly well formed, some broken, some noise
        while (rx_pending.size() < 400) begin
            sel = $urandom_range(0, 99);
            op  = ($urandom_range(0, 99) < 85) ? SUB_VERSION + 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
            if (sel < 40) begin
                queue_frame(OP_READ, op, rand_data(), rand_data(), rand_data(), 1'b0);
            end else if (sel < 75) begin
                queue_frame(OP_WRITE, op, rand_data(), rand_data(), rand_data(), 1'b0);
            end else if (sel < 85) begin
                do
                    op = 8'($urandom_range(0, 255));
                while (op == OP_READ || op == OP_WRITE);
                queue_frame(op, rand_data(), rand_data(), rand_data(), rand_data(), 1'b0);
            end else if (sel < 95) begin
                queue_frame($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                            SUB_VERSION + 8'($urandom_range(0, 3)),
                            rand_data(), rand_data(), rand_data(), 1'b1);
            end else begin
                for (int k = 0; k < FRAME_LEN; k++)
                    rx_pending.push_back(8'($urandom_range(0, 255)));
            end
        end

        // Hold reset, then release it away from the rising edge
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain input, then output, then let the block settle
        while (rx_pending.size() != 0 || rx_valid)
            @(negedge clk);
        while (tx_bytes_due.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        if (tx_bytes_due.size() != 0) begin
            $error("%0d tx transfers never arrived", tx_bytes_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- framed_command_handler_crc16.f -----
+incdir+hw/rtl
hw/rtl/fch_pkg.sv
hw/rtl/fch_crc.sv
hw/rtl/fch_regs.sv
hw/rtl/framed_command_handler_crc16.sv
hw/rtl/fch_checker.sv
tb/sv/tb.sv
